/* rtl/eiprx_pkg.sv */
`default_nettype none
// Package for the Ethernet/IPv4 receive classifier: class codes, header offsets and widths.
// No dependencies; used by the top level and the checker.
package eiprx_pkg;

  localparam int unsigned CountW = 12;

  // Bytes beyond this count are neither counted nor captured.
  localparam logic [CountW-1:0] MaxFrame = 12'd2048;

  typedef enum logic [2:0] {
    ClsReject = 3'd0,
    ClsArp    = 3'd1,
    ClsTcp    = 3'd2,
    ClsIcmp   = 3'd3,
    ClsDhcp   = 3'd4,
    ClsDns    = 3'd5,
    ClsUdp    = 3'd6,
    ClsIpDrop = 3'd7
  } frame_class_e;

  localparam logic [CountW-1:0] OffTypeHi  = 12'd12;
  localparam logic [CountW-1:0] OffTypeLo  = 12'd13;
  localparam logic [CountW-1:0] OffIhl     = 12'd14;
  localparam logic [CountW-1:0] OffTotHi   = 12'd16;
  localparam logic [CountW-1:0] OffTotLo   = 12'd17;
  localparam logic [CountW-1:0] OffProto   = 12'd23;
  localparam logic [CountW-1:0] OffPortHi  = 12'd36;
  localparam logic [CountW-1:0] OffPortLo  = 12'd37;

  localparam logic [CountW-1:0] EthHdrLen  = 12'd14;
  localparam logic [CountW-1:0] MinIpLen   = 12'd34;
  localparam logic [CountW-1:0] MinUdpLen  = 12'd42;
  localparam logic [5:0]        MinIhlLen  = 6'd20;

  localparam logic [15:0] EtherTypeArp   = 16'h0806;
  localparam logic [15:0] EtherTypeIpv4  = 16'h0800;
  localparam logic [7:0]  ProtoIcmp      = 8'd1;
  localparam logic [7:0]  ProtoTcp       = 8'd6;
  localparam logic [7:0]  ProtoUdp       = 8'd17;
  localparam logic [15:0] PortDhcpClient = 16'd68;

endpackage
`default_nettype wire

/* rtl/eiprx_in_if.sv */
`default_nettype none
// Receive byte stream channel: valid/ready handshake with one frame byte and a last mark.
// No dependencies.
interface eiprx_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       last_byte;

  modport source (output valid, output frame_byte, output last_byte, input ready);
  modport sink   (input valid, input frame_byte, input last_byte, output ready);
endinterface
`default_nettype wire

/* rtl/eiprx_out_if.sv */
`default_nettype none
// Classification result channel: valid/ready handshake with class, wake flag and length.
// No dependencies.
interface eiprx_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  frame_class;
  logic        wake;
  logic [11:0] frame_length;

  modport source (output valid, output frame_class, output wake, output frame_length,
                  input ready);
  modport sink   (input valid, input frame_class, input wake, input frame_length,
                  output ready);
endinterface
`default_nettype wire

/* rtl/ethernet_ipv4_rx_classifier.sv */
`default_nettype none
// Ethernet/IPv4 receive classifier top level.
// Depends on eiprx_pkg, eiprx_in_if and eiprx_out_if.
//
// Usage: frame bytes enter on in_i in wire order, one per transfer, with last_byte set
// on the final byte. One transfer may be taken in every cycle. Header fields are
// captured as the bytes stream past; on the last byte they are copied into a snapshot
// register and the frame state is cleared, so the next frame may start at once.
// The class is then computed from the snapshot and loaded into the output register
// once that is free, and out_o shows it from that register. Throughput is one byte per
// cycle; the snapshot and output registers each hold one result. When the receiver
// stalls, the output holds, the snapshot fills, and in_i drops ready only while both
// are full. The user must write the dns_port register through cfg_we_i/cfg_wdata_i
// only while the block is idle; the block does not enforce this. Reset clears the
// frame state, both valid flags and dns_port; no clearing pass is needed.
module ethernet_ipv4_rx_classifier (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  eiprx_in_if.sink         in_i,
  eiprx_out_if.source      out_o,
  input  wire logic        cfg_we_i,
  input  wire logic [15:0] cfg_wdata_i
);
  import eiprx_pkg::*;

  logic [15:0]       dns_port_q;
  logic [CountW-1:0] cnt_q, cnt_d, cnt_cur;
  logic [15:0]       etype_q, etype_d, etype_cur;
  logic [3:0]        words_q, words_d, words_cur;
  logic [15:0]       totlen_q, totlen_d, totlen_cur;
  logic [7:0]        proto_q, proto_d, proto_cur;
  logic [15:0]       port_q, port_d, port_cur;

  logic              snap_vld_q, snap_vld_d;
  logic [CountW-1:0] s_len_q;
  logic [15:0]       s_etype_q;
  logic [3:0]        s_words_q;
  logic [15:0]       s_totlen_q;
  logic [7:0]        s_proto_q;
  logic [15:0]       s_port_q;

  logic              out_vld_q, out_vld_d;
  frame_class_e      out_cls_q, cls;
  logic [CountW-1:0] out_len_q;

  logic              accept, frame_done, out_free;
  logic [5:0]        hdr_len;
  logic [CountW-1:0] hdr_end;
  logic [16:0]       tot_end;

  assign out_free   = !out_vld_q || out_o.ready;
  assign in_i.ready = !snap_vld_q || out_free;
  assign accept     = in_i.valid && in_i.ready;
  assign frame_done = accept && in_i.last_byte;

  always_comb begin
    cnt_cur    = cnt_q;
    etype_cur  = etype_q;
    words_cur  = words_q;
    totlen_cur = totlen_q;
    proto_cur  = proto_q;
    port_cur   = port_q;
    if (cnt_q < MaxFrame) begin
      cnt_cur = cnt_q + 12'd1;
      if (cnt_q == OffTypeHi) etype_cur[15:8]  = in_i.frame_byte;
      if (cnt_q == OffTypeLo) etype_cur[7:0]   = in_i.frame_byte;
      if (cnt_q == OffIhl)    words_cur        = in_i.frame_byte[3:0];
      if (cnt_q == OffTotHi)  totlen_cur[15:8] = in_i.frame_byte;
      if (cnt_q == OffTotLo)  totlen_cur[7:0]  = in_i.frame_byte;
      if (cnt_q == OffProto)  proto_cur        = in_i.frame_byte;
      if (cnt_q == OffPortHi) port_cur[15:8]   = in_i.frame_byte;
      if (cnt_q == OffPortLo) port_cur[7:0]    = in_i.frame_byte;
    end
  end

  always_comb begin
    cnt_d    = cnt_q;
    etype_d  = etype_q;
    words_d  = words_q;
    totlen_d = totlen_q;
    proto_d  = proto_q;
    port_d   = port_q;
    if (frame_done) begin
      cnt_d    = '0;
      etype_d  = '0;
      words_d  = '0;
      totlen_d = '0;
      proto_d  = '0;
      port_d   = '0;
    end else if (accept) begin
      cnt_d    = cnt_cur;
      etype_d  = etype_cur;
      words_d  = words_cur;
      totlen_d = totlen_cur;
      proto_d  = proto_cur;
      port_d   = port_cur;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q      <= '0;
      etype_q    <= '0;
      words_q    <= '0;
      totlen_q   <= '0;
      proto_q    <= '0;
      port_q     <= '0;
      dns_port_q <= '0;
    end else begin
      cnt_q    <= cnt_d;
      etype_q  <= etype_d;
      words_q  <= words_d;
      totlen_q <= totlen_d;
      proto_q  <= proto_d;
      port_q   <= port_d;
      if (cfg_we_i) begin
        dns_port_q <= cfg_wdata_i;
      end
    end
  end

  always_comb begin
    snap_vld_d = snap_vld_q;
    if (frame_done) begin
      snap_vld_d = 1'b1;
    end else if (out_free) begin
      snap_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (frame_done) begin
      s_len_q    <= cnt_cur;
      s_etype_q  <= etype_cur;
      s_words_q  <= words_cur;
      s_totlen_q <= totlen_cur;
      s_proto_q  <= proto_cur;
      s_port_q   <= port_cur;
    end
  end

  assign hdr_len = {s_words_q, 2'b00};
  assign hdr_end = EthHdrLen + {6'd0, hdr_len};
  assign tot_end = {1'b0, s_totlen_q} + {5'd0, EthHdrLen};

  always_comb begin
    if (s_len_q < EthHdrLen) begin
      cls = ClsReject;
    end else if (s_etype_q == EtherTypeArp) begin
      cls = ClsArp;
    end else if (s_etype_q != EtherTypeIpv4 || s_len_q < MinIpLen) begin
      cls = ClsReject;
    end else if (hdr_len < MinIhlLen || hdr_end > s_len_q) begin
      cls = ClsReject;
    end else if (s_totlen_q < {10'd0, hdr_len} || tot_end > {5'd0, s_len_q}) begin
      cls = ClsReject;
    end else if (s_proto_q == ProtoTcp) begin
      cls = ClsTcp;
    end else if (s_proto_q == ProtoIcmp) begin
      cls = ClsIcmp;
    end else if (s_proto_q == ProtoUdp && s_len_q >= MinUdpLen) begin
      if (s_port_q == PortDhcpClient) begin
        cls = ClsDhcp;
      end else if (dns_port_q != 16'd0 && s_port_q == dns_port_q) begin
        cls = ClsDns;
      end else begin
        cls = ClsUdp;
      end
    end else begin
      cls = ClsIpDrop;
    end
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (out_free) begin
      out_vld_d = snap_vld_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      snap_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      snap_vld_q <= snap_vld_d;
      out_vld_q  <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && snap_vld_q) begin
      out_cls_q <= cls;
      out_len_q <= s_len_q;
    end
  end

  assign out_o.valid        = out_vld_q;
  assign out_o.frame_class  = out_cls_q;
  assign out_o.wake         = (out_cls_q == ClsTcp) || (out_cls_q == ClsIcmp) ||
                              (out_cls_q == ClsDhcp) || (out_cls_q == ClsDns) ||
                              (out_cls_q == ClsUdp);
  assign out_o.frame_length = out_len_q;

endmodule
`default_nettype wire

/* rtl/eiprx_checker.sv */
`default_nettype none
// Port-level checker for the Ethernet/IPv4 receive classifier, with its bind statement.
// Depends on eiprx_pkg and the top level ethernet_ipv4_rx_classifier.
module eiprx_checker (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        out_valid_i,
  input  wire logic        out_ready_i,
  input  wire logic [2:0]  frame_class_i,
  input  wire logic        wake_i,
  input  wire logic [11:0] frame_length_i
);
  import eiprx_pkg::*;

  // A stalled result keeps its content.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(frame_class_i) &&
    $stable(frame_length_i))
    else $error("stalled result changed");

  // The wake flag marks exactly the classes handed to a protocol.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> wake_i == (frame_class_i == ClsTcp || frame_class_i == ClsIcmp ||
                               frame_class_i == ClsDhcp || frame_class_i == ClsDns ||
                               frame_class_i == ClsUdp))
    else $error("wake flag disagrees with class");

  // Every frame has at least one byte, and the count saturates.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> frame_length_i != 12'd0 && frame_length_i <= MaxFrame)
    else $error("frame length out of range");

  // Any accepted class needs at least a full Ethernet header, and IPv4 ones an IP header.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && frame_class_i != ClsReject |->
    frame_length_i >= EthHdrLen &&
    (frame_class_i == ClsArp || frame_length_i >= MinIpLen))
    else $error("class given to a frame too short for it");

endmodule

bind ethernet_ipv4_rx_classifier eiprx_checker u_eiprx_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .frame_class_i  (out_o.frame_class),
  .wake_i         (out_o.wake),
  .frame_length_i (out_o.frame_length)
);
`default_nettype wire
